### hdl/ipdd_pkg.sv
// Shared types and constants for the IR pulse-distance decoder.
// No dependencies; every other file depends on this package.
package ipdd_pkg;

	localparam int DUR_W     = 16;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CODE_W    = 64;
	localparam int CNT_W     = 7;
	localparam int MaxBits   = 64;

	localparam logic [CFG_W-1:0] SYNC_MIN_RST  = 16'd4300;
	localparam logic [CFG_W-1:0] SYNC_MAX_RST  = 16'd4800;
	localparam logic [CFG_W-1:0] SHORT_MIN_RST = 16'd400;
	localparam logic [CFG_W-1:0] SHORT_MAX_RST = 16'd700;
	localparam logic [CFG_W-1:0] LONG_MIN_RST  = 16'd1500;
	localparam logic [CFG_W-1:0] LONG_MAX_RST  = 16'd1800;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SYNC_MIN  = 3'd0,
		REG_SYNC_MAX  = 3'd1,
		REG_SHORT_MIN = 3'd2,
		REG_SHORT_MAX = 3'd3,
		REG_LONG_MIN  = 3'd4,
		REG_LONG_MAX  = 3'd5
	} reg_idx_t;

	typedef enum logic [2:0] {
		CLS_UNKNOWN    = 3'd0,
		CLS_SYNC_LOW   = 3'd1,
		CLS_SYNC_HIGH  = 3'd2,
		CLS_SHORT_LOW  = 3'd3,
		CLS_SHORT_HIGH = 3'd4,
		CLS_LONG_HIGH  = 3'd5
	} cls_t;

	typedef enum logic [1:0] {
		EV_NONE  = 2'd0,
		EV_START = 2'd1,
		EV_BIT   = 2'd2,
		EV_END   = 2'd3
	} ev_t;

	typedef struct packed {
		logic [CFG_W-1:0] sync_min;
		logic [CFG_W-1:0] sync_max;
		logic [CFG_W-1:0] short_min;
		logic [CFG_W-1:0] short_max;
		logic [CFG_W-1:0] long_min;
		logic [CFG_W-1:0] long_max;
	} win_cfg_t;

	typedef struct packed {
		ev_t               event_res;
		logic              bit_value;
		logic [CNT_W-1:0]  bit_count;
		logic [CODE_W-1:0] code_word;
		logic              overflow;
	} res_t;

endpackage

### hdl/ipdd_ifs.sv
// Valid/ready channel interfaces for the decoder's pulse input and result output.
// Depends on ipdd_pkg for field widths.
interface ipdd_pulse_if;
	logic                       valid;
	logic                       ready;
	logic [ipdd_pkg::DUR_W-1:0] duration;
	logic                       was_high;
	modport source(output valid, duration, was_high, input ready);
	modport sink(input valid, duration, was_high, output ready);
endinterface

interface ipdd_result_if;
	logic                        valid;
	logic                        ready;
	logic [1:0]                  event_res;
	logic                        bit_value;
	logic [ipdd_pkg::CNT_W-1:0]  bit_count;
	logic [ipdd_pkg::CODE_W-1:0] code_word;
	logic                        overflow;
	modport source(output valid, event_res, bit_value, bit_count, code_word, overflow,
		input ready);
	modport sink(input valid, event_res, bit_value, bit_count, code_word, overflow,
		output ready);
endinterface

### hdl/ipdd_cfg_regs.sv
// Window configuration registers of the decoder, written through a plain write port.
// Depends on ipdd_pkg.
module ipdd_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [ipdd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ipdd_pkg::CFG_W-1:0]     cfg_wdata,
	output ipdd_pkg::win_cfg_t             win
);
	import ipdd_pkg::*;

	win_cfg_t win_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q.sync_min  <= SYNC_MIN_RST;
			win_q.sync_max  <= SYNC_MAX_RST;
			win_q.short_min <= SHORT_MIN_RST;
			win_q.short_max <= SHORT_MAX_RST;
			win_q.long_min  <= LONG_MIN_RST;
			win_q.long_max  <= LONG_MAX_RST;
		end else if (cfg_we) begin
			// indexes past the last register are dropped
			unique case (cfg_index)
				REG_SYNC_MIN:  win_q.sync_min  <= cfg_wdata;
				REG_SYNC_MAX:  win_q.sync_max  <= cfg_wdata;
				REG_SHORT_MIN: win_q.short_min <= cfg_wdata;
				REG_SHORT_MAX: win_q.short_max <= cfg_wdata;
				REG_LONG_MIN:  win_q.long_min  <= cfg_wdata;
				REG_LONG_MAX:  win_q.long_max  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign win = win_q;

endmodule

### hdl/ipdd_classify.sv
// Sorts one interval into sync / short / long classes by open windows.
// Depends on ipdd_pkg.
module ipdd_classify (
	input  logic [ipdd_pkg::DUR_W-1:0] duration,
	input  logic                       was_high,
	input  ipdd_pkg::win_cfg_t         win,
	output ipdd_pkg::cls_t             cls
);
	import ipdd_pkg::*;

	logic in_sync, in_short, in_long;

	assign in_sync  = (duration > win.sync_min)  && (duration < win.sync_max);
	assign in_short = (duration > win.short_min) && (duration < win.short_max);
	assign in_long  = (duration > win.long_min)  && (duration < win.long_max);

	// first matching window wins; a long low is unknown
	always_comb begin
		priority if (in_sync)
			cls = was_high ? CLS_SYNC_HIGH : CLS_SYNC_LOW;
		else if (in_short)
			cls = was_high ? CLS_SHORT_HIGH : CLS_SHORT_LOW;
		else if (in_long && was_high)
			cls = CLS_LONG_HIGH;
		else
			cls = CLS_UNKNOWN;
	end

endmodule

### hdl/ipdd_frame.sv
// Frame tracker: holds frame state, builds the result for the current interval
// and commits the new state when the item moves into the result register. Depends on ipdd_pkg.
module ipdd_frame (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           adv,
	input  ipdd_pkg::cls_t cls,
	output ipdd_pkg::res_t res
);
	import ipdd_pkg::*;

	logic              in_frame_q, in_frame_d;
	cls_t              last_cls_q;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [CODE_W-1:0] code_q, code_d;
	logic              is_bit, bit_v, ends;
	logic [5:0]        bit_pos;

	always_comb begin
		in_frame_d    = in_frame_q;
		count_d       = count_q;
		code_d        = code_q;
		res.event_res = EV_NONE;
		res.bit_value = 1'b0;
		res.overflow  = 1'b0;
		is_bit        = (last_cls_q == CLS_SHORT_LOW) &&
			(cls == CLS_LONG_HIGH || cls == CLS_SHORT_HIGH);
		bit_v         = (cls == CLS_LONG_HIGH);
		ends          = !(cls == CLS_SHORT_LOW || cls == CLS_SHORT_HIGH ||
			cls == CLS_LONG_HIGH);
		// first bit lands in the MSB: position is 63 - count
		bit_pos       = ~count_q[5:0];
		if (!in_frame_q) begin
			if (cls == CLS_SYNC_HIGH && last_cls_q == CLS_SYNC_LOW) begin
				in_frame_d    = 1'b1;
				count_d       = '0;
				code_d        = '0;
				res.event_res = EV_START;
			end
		end else if (is_bit) begin
			if (count_q < CNT_W'(MaxBits)) begin
				code_d[bit_pos] = code_q[bit_pos] | bit_v;
				count_d         = count_q + CNT_W'(1);
				res.event_res   = EV_BIT;
				res.bit_value   = bit_v;
			end else begin
				res.overflow = 1'b1;
			end
		end else if (ends) begin
			// code keeps the finished frame for the ending result
			in_frame_d    = 1'b0;
			count_d       = '0;
			res.event_res = EV_END;
		end
		res.bit_count = count_d;
		res.code_word = code_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			last_cls_q <= CLS_UNKNOWN;
			count_q    <= '0;
			code_q     <= '0;
		end else if (adv) begin
			in_frame_q <= in_frame_d;
			last_cls_q <= cls;
			count_q    <= count_d;
			code_q     <= code_d;
		end
	end

endmodule

### hdl/ir_pulse_distance_decoder.sv
// Top level of the IR pulse-distance decoder: input register, classifier,
// frame tracker and result register. Depends on ipdd_pkg, ipdd_ifs and the ipdd_* modules.
//
// Usage:
//   pulse  : one transfer per ended line interval (duration in us, was_high).
//   result : one transfer per pulse item: event (none/start/bit/end), bit value,
//            bit count, 64-bit code word (first bit in the MSB) and overflow flag.
//   cfg    : cfg_we/cfg_index/cfg_wdata write the six window bounds
//            (sync, short, long; min then max; exclusive). Write only while idle.
// Path: a pulse passes two registers, the input stage and then the result register;
//   classify and frame update sit between them.
// Throughput: one item per cycle while result.ready is high; pulse.ready stays high while the result register
//   is empty or being drained, so the input stage and the result register each hold an item.
// Reset: arst_n clears both stages, closes any frame, zeroes count and code and
//   loads the default windows 4300-4800, 400-700, 1500-1800 us.
// Stall: while result.ready is low the result holds; the input stage takes one more
//   item and then pulse.ready drops until the result is taken.
module ir_pulse_distance_decoder (
	input  logic                           clk,
	input  logic                           arst_n,
	ipdd_pulse_if.sink                     pulse,
	ipdd_result_if.source                  result,
	input  logic                           cfg_we,
	input  logic [ipdd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ipdd_pkg::CFG_W-1:0]     cfg_wdata
);
	import ipdd_pkg::*;

	logic             vld_s1;
	logic [DUR_W-1:0] dur_s1;
	logic             high_s1;
	logic             vld_s2;
	res_t             res_s2;
	res_t             res_nxt;
	win_cfg_t         win;
	cls_t             cls;
	logic             adv;

	// the s1 item moves into the result register when that register is free or draining
	assign adv         = vld_s1 && (!vld_s2 || result.ready);
	assign pulse.ready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (pulse.ready)
				vld_s1 <= pulse.valid;
			if (adv)
				vld_s2 <= 1'b1;
			else if (result.ready)
				vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pulse.ready && pulse.valid) begin
			dur_s1  <= pulse.duration;
			high_s1 <= pulse.was_high;
		end
		if (adv)
			res_s2 <= res_nxt;
	end

	ipdd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.win       (win)
	);

	ipdd_classify u_cls (
		.duration (dur_s1),
		.was_high (high_s1),
		.win      (win),
		.cls      (cls)
	);

	ipdd_frame u_frame (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.cls    (cls),
		.res    (res_nxt)
	);

	assign result.valid     = vld_s2;
	assign result.event_res = res_s2.event_res;
	assign result.bit_value = res_s2.bit_value;
	assign result.bit_count = res_s2.bit_count;
	assign result.code_word = res_s2.code_word;
	assign result.overflow  = res_s2.overflow;

endmodule
